### rtl/status_keyword_mask_parser_unit_macros.svh
// assertion macros shared by the status keyword mask parser rtl
// no dependencies; include guarded, empty bodies under synthesis
`ifndef STATUS_KEYWORD_MASK_PARSER_UNIT_MACROS_SVH
`define STATUS_KEYWORD_MASK_PARSER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SKMP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("skmp assertion failed")
`define SKMP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("skmp assertion failed")
`else
`define SKMP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SKMP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/skmp_pkg.sv
// types, keyword table and bit positions for the status keyword mask parser
// no dependencies
package skmp_pkg;

    localparam int KW_COUNT = 15;

    localparam logic [KW_COUNT-1:0] ALL_ALIVE = '1;

    localparam int BIT_CAL     = 0;
    localparam int BIT_OL      = 3;
    localparam int BIT_OB      = 4;
    localparam int BIT_CHRG    = 10;
    localparam int BIT_DISCHRG = 11;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // keyword text, first byte in the top byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        {"CAL",     40'h0},
        {"TRIM",    32'h0},
        {"BOOST",   24'h0},
        {"OL",      48'h0},
        {"OB",      48'h0},
        {"OVER",    32'h0},
        {"LB",      48'h0},
        {"RB",      48'h0},
        {"BYPASS",  16'h0},
        {"OFF",     40'h0},
        {"CHRG",    32'h0},
        {"DISCHRG", 8'h0},
        {"HB",      48'h0},
        {"FSD",     40'h0},
        {"ALARM",   24'h0}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd4, 3'd5, 3'd2, 3'd2, 3'd4, 3'd2, 3'd2,
        3'd6, 3'd3, 3'd4, 3'd7, 3'd2, 3'd3, 3'd5
    };

    typedef struct packed {
        logic [7:0] character;
        logic       char_valid;
        logic       end_of_string;
        logic       test_in_progress;
    } skmp_item_t;

    function automatic logic [7:0] kw_byte(input logic [3:0] k, input logic [2:0] p);
        logic [2:0]  q;
        logic [63:0] t;
        q = 3'd7 - p;
        t = KW_TEXT[k];
        return t[8*q +: 8];
    endfunction

endpackage

### rtl/skmp_match.sv
// keyword match state and end of string mask fixup
// depends on skmp_pkg and the assertion macro header
`include "status_keyword_mask_parser_unit_macros.svh"
module skmp_match
    import skmp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  skmp_item_t          item,
    output logic [KW_COUNT-1:0] result_mask
);

    logic [KW_COUNT-1:0] alive_reg, alive_next;
    logic [3:0]          pos_reg, pos_next;
    logic [KW_COUNT-1:0] acc_reg, acc_next;

    logic [7:0]          c_fold;
    logic [KW_COUNT-1:0] alive_tok;
    logic [3:0]          pos_tok;
    logic [KW_COUNT-1:0] acc_tok;
    logic [KW_COUNT-1:0] mask_pre;
    logic                kw_match;
    logic                kw_hit;

    always_comb begin
        if (item.character >= CHAR_LOWER_A && item.character <= CHAR_LOWER_Z) begin
            c_fold = item.character - CASE_OFFSET;
        end else begin
            c_fold = item.character;
        end
    end

    // one byte against every keyword in parallel
    always_comb begin
        alive_tok = alive_reg;
        pos_tok   = pos_reg;
        acc_tok   = acc_reg;
        kw_match  = 1'b0;
        kw_hit    = 1'b0;
        if (item.char_valid) begin
            if (item.character == CHAR_SPACE) begin
                alive_tok = ALL_ALIVE;
                pos_tok   = 4'd0;
            end else begin
                for (int k = 0; k < KW_COUNT; k++) begin
                    kw_match = alive_reg[k] && (pos_reg < {1'b0, KW_LEN[k]})
                               && (kw_byte(4'(k), pos_reg[2:0]) == c_fold);
                    kw_hit   = kw_match && ((pos_reg + 4'd1) == {1'b0, KW_LEN[k]});
                    alive_tok[k] = kw_match && !kw_hit;
                    if (kw_hit) begin
                        acc_tok[k] = 1'b1;
                    end
                end
                if (pos_reg != 4'hF) begin
                    pos_tok = pos_reg + 4'd1;
                end
            end
        end
    end

    always_comb begin
        mask_pre = acc_tok;
        if (item.test_in_progress) begin
            mask_pre[BIT_CAL] = 1'b1;
        end
        result_mask = mask_pre;
        if (!mask_pre[BIT_OL] && !mask_pre[BIT_OB]) begin
            if (mask_pre[BIT_CHRG] && !mask_pre[BIT_DISCHRG]) begin
                result_mask[BIT_OL] = 1'b1;
            end else if (!mask_pre[BIT_CHRG] && mask_pre[BIT_DISCHRG]) begin
                result_mask[BIT_OB] = 1'b1;
            end
        end
    end

    always_comb begin
        alive_next = alive_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        if (step) begin
            if (item.end_of_string) begin
                alive_next = ALL_ALIVE;
                pos_next   = 4'd0;
                acc_next   = '0;
            end else begin
                alive_next = alive_tok;
                pos_next   = pos_tok;
                acc_next   = acc_tok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= ALL_ALIVE;
            pos_reg   <= 4'd0;
            acc_reg   <= '0;
        end else begin
            alive_reg <= alive_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
        end
    end

    `SKMP_ASSERT_NEXT(a_end_clears, aclk, aresetn, step && item.end_of_string,
        alive_reg == ALL_ALIVE && pos_reg == 4'd0 && acc_reg == '0);
    `SKMP_ASSERT_NEXT(a_space_restarts, aclk, aresetn,
        step && item.char_valid && item.character == CHAR_SPACE,
        alive_reg == ALL_ALIVE && pos_reg == 4'd0);

endmodule

### rtl/status_keyword_mask_parser_unit.sv
// Status keyword mask parser, top level.
// Input channel s_*: one beat per status text byte (s_character, s_char_valid),
// with s_end_of_string marking the last beat of a text and s_test_in_progress
// sampled on that beat. s_char_valid low with end set closes an empty text.
// Result channel m_*: one beat per text, m_status_mask with bit0 CAL up to
// bit14 ALARM; beats without end produce no result.
// Throughput: one input beat per cycle while s_ready is high. A beat lands in
// the input register, is matched combinationally against all 15 keywords and,
// on end of text, the mask is written to the output register that drives
// m_status_mask and m_valid.
// When m_ready is low with a result pending, beats without end keep flowing;
// an end beat waits in the input register and s_ready drops.
// Reset (aresetn low, synchronous) clears the valid flags of both registers and
// the keyword match state, so the next beat starts a new text.
// depends on skmp_pkg, skmp_match and the assertion macro header
`include "status_keyword_mask_parser_unit_macros.svh"
module status_keyword_mask_parser_unit
    import skmp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_character,
    input  logic                s_char_valid,
    input  logic                s_end_of_string,
    input  logic                s_test_in_progress,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [KW_COUNT-1:0] m_status_mask
);

    logic                in_valid_reg;
    skmp_item_t          in_item_reg;
    logic                out_valid_reg;
    logic [KW_COUNT-1:0] out_mask_reg;
    logic                fire;
    logic                out_free;
    logic [KW_COUNT-1:0] result_mask;

    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && (!in_item_reg.end_of_string || out_free);
    assign s_ready  = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= '{character:        s_character,
                             char_valid:       s_char_valid,
                             end_of_string:    s_end_of_string,
                             test_in_progress: s_test_in_progress};
        end
    end

    skmp_match u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (fire),
        .item        (in_item_reg),
        .result_mask (result_mask)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && in_item_reg.end_of_string) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_item_reg.end_of_string) begin
            out_mask_reg <= result_mask;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status_mask = out_mask_reg;

    `SKMP_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, s_valid && s_ready && in_valid_reg, fire);
    `SKMP_ASSERT_NEXT(a_held_beat, aclk, aresetn, in_valid_reg && !fire, in_valid_reg);
    `SKMP_ASSERT_IMPL(a_result_source, aclk, aresetn, $rose(out_valid_reg),
        $past(fire && in_item_reg.end_of_string));

endmodule
